### rtl/core/pow2ts_pkg.sv
`timescale 1ns / 1ps

package pow2ts_pkg;

    localparam int EXT_W  = 16;
    localparam int SZ_W   = 17;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 6;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] REG_MIN_W   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_MAX_W   = 3'd1;
    localparam logic [ADDR_W-1:0] REG_MIN_H   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_MAX_H   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_SINGLE  = 3'd4;

    localparam logic [CFG_W-1:0] MIN_RESET = 16'd1;
    localparam logic [CFG_W-1:0] MAX_RESET = 16'd65535;

    typedef struct packed {
        logic load;
        logic round_step;
        logic scan_step;
        logic merge;
        logic shift_step;
        logic emit_hi;
        logic emit_lo;
        logic emit_err;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_err;
        logic round_done;
        logic lo_gt_hi;
        logic scan_last;
        logic over;
        logic div_done;
        logic hi_zero;
        logic hi_last;
        logic lo_hit;
        logic lo_last;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/core/pow2ts_if.sv
`timescale 1ns / 1ps

interface pow2ts_in_if;
    import pow2ts_pkg::*;

    logic             valid;
    logic             ready;
    logic [EXT_W-1:0] extent;
    logic             axis;

    modport source (output valid, output extent, output axis, input ready);
    modport sink (input valid, input extent, input axis, output ready);
endinterface

interface pow2ts_out_if;
    import pow2ts_pkg::*;

    logic             valid;
    logic             ready;
    logic [SZ_W-1:0]  tile_size;
    logic [IDX_W-1:0] tile_index;
    logic             last;
    logic             error;

    modport source (output valid, output tile_size, output tile_index, output last,
                    output error, input ready);
    modport sink (input valid, input tile_size, input tile_index, input last,
                  input error, output ready);
endinterface

### rtl/core/pow2_tile_size_splitter_unit.sv
`timescale 1ns / 1ps
// channel   dir   fields                                  handshake
// req       in    extent[15:0], axis                      valid / ready
// tile      out   tile_size[16:0], tile_index[5:0],       valid / ready
//                 last, error
// cfg       in    cfg_addr[2:0], cfg_data[15:0]           cfg_we
//
// one item at a time: limit rounding, a check, a scan over the extent bits, a merge, a
// shift that counts maximum-size tiles, then the maximum-size tiles, a step below the
// maximum and a walk down the bits above the smallest tile; errors come early.
// reset puts the limit registers at their defaults; there is no memory to clear.
// words leave through an output register; a stalled tile.ready holds the sequencer's emit states,
// and req.ready rises again once the final word sits in the output register.

module pow2_tile_size_splitter_unit #(
    parameter int MAX_BLOCKS  = 64,
    parameter int EXTENT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pow2ts_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [pow2ts_pkg::CFG_W-1:0]  cfg_data,
    pow2ts_in_if.sink                     req,
    pow2ts_out_if.source                  tile
);
    import pow2ts_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     ctrl_ready;

    assign req.ready = ctrl_ready;

    pow2ts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (req.valid),
        .ready (ctrl_ready),
        .stat  (stat),
        .cmd   (cmd)
    );

    pow2ts_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .extent   (req.extent),
        .axis     (req.axis),
        .cmd      (cmd),
        .stat     (stat),
        .tile     (tile)
    );

`ifndef NO_ASSERTIONS
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        tile.valid && tile.error |-> tile.last && (tile.tile_size == '0))
        else $error("error word is not a closing zero-size word");

    a_size_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        tile.valid && !tile.error |-> $onehot(tile.tile_size))
        else $error("tile size is not a power of two");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready && cmd.load == 1'b0)
        else $error("second item taken while one is in work");
`endif

endmodule

### rtl/core/pow2ts_ctrl.sv
`timescale 1ns / 1ps

module pow2ts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 ready,
    input  pow2ts_pkg::dp_stat_t stat,
    output pow2ts_pkg::dp_cmd_t  cmd
);
    import pow2ts_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_ROUND   = 9'b000000010,
        S_CHECK   = 9'b000000100,
        S_SCAN    = 9'b000001000,
        S_MERGE   = 9'b000010000,
        S_SHIFT   = 9'b000100000,
        S_EMIT_HI = 9'b001000000,
        S_EMIT_LO = 9'b010000000,
        S_ERR     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (stat.zero_err)
                    state_next = S_ERR;
                else if (stat.round_done)
                    state_next = S_CHECK;
                else
                    cmd.round_step = 1'b1;
            end
            S_CHECK:
            begin
                state_next = stat.lo_gt_hi ? S_ERR : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (stat.over)
                    state_next = S_ERR;
                else
                begin
                    cmd.merge  = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.div_done)
                    state_next = S_EMIT_HI;
                else
                    cmd.shift_step = 1'b1;
            end
            S_EMIT_HI:
            begin
                if (stat.hi_zero)
                    state_next = S_EMIT_LO;
                else if (stat.out_free)
                begin
                    cmd.emit_hi = 1'b1;
                    if (stat.hi_last)
                        state_next = S_IDLE;
                end
            end
            S_EMIT_LO:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_lo = 1'b1;
                    if (stat.lo_hit && stat.lo_last)
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/pow2ts_dp.sv
`timescale 1ns / 1ps

module pow2ts_dp #(
    parameter int MAX_BLOCKS  = 64,
    parameter int EXTENT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pow2ts_pkg::ADDR_W-1:0]         cfg_addr,
    input  logic [pow2ts_pkg::CFG_W-1:0]          cfg_data,
    input  logic [pow2ts_pkg::EXT_W-1:0]          extent,
    input  logic                                  axis,
    input  pow2ts_pkg::dp_cmd_t                   cmd,
    output pow2ts_pkg::dp_stat_t                  stat,
    pow2ts_out_if.source                          tile
);
    import pow2ts_pkg::*;

    localparam int SCAN_BITS = (EXTENT_BITS < EXT_W) ? EXTENT_BITS : EXT_W;
    localparam logic [EXT_W:0]   ONE_X    = 1;
    localparam logic [EXT_W-1:0] EXT_MASK = EXT_W'((ONE_X << SCAN_BITS) - ONE_X);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_BLOCKS + 1);
    localparam logic [SZ_W-1:0]  ONE_S   = 1;

    // configuration registers
    logic [CFG_W-1:0] min_w_reg, max_w_reg, min_h_reg, max_h_reg;
    logic             single_cfg_reg;

    // per-item working registers
    logic [EXT_W-1:0] ext_reg;
    logic [CFG_W-1:0] lo_lim_reg, hi_lim_reg;
    logic             single_reg;
    logic [SZ_W-1:0]  lo_reg, hi_reg, p_reg, weight_reg, small_top_reg;
    logic [SZ_W-1:0]  w_reg, r_reg, d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             small_any_reg, small_two_reg;
    logic [IDX_W-1:0] idx_reg;

    // output register
    logic             out_valid_reg;
    logic [SZ_W-1:0]  out_size_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_last_reg;
    logic             out_err_reg;

    logic [SZ_W-1:0]  ext_x;
    logic [SZ_W-1:0]  hi_dbl;
    logic             bit_set;
    logic [SZ_W:0]    cnt_sum;
    logic             merge_go;
    logic [SZ_W-1:0]  tail;
    logic [SZ_W-1:0]  w_new;
    logic             out_load;

    assign ext_x   = SZ_W'(ext_reg);
    assign hi_dbl  = hi_reg << 1;
    assign bit_set = |(ext_x & p_reg);
    assign cnt_sum = (SZ_W+1)'(cnt_reg) + (SZ_W+1)'(weight_reg);

    // tail of small tiles collapses into one; a carry ripples up through set bits
    assign merge_go = small_any_reg && (!single_reg || small_two_reg);
    assign tail     = single_reg ? (small_top_reg << 1) : lo_reg;
    assign w_new    = merge_go ? ((ext_x & ~(lo_reg - ONE_S)) + tail) : ext_x;

    assign out_load = cmd.emit_hi || cmd.emit_err || (cmd.emit_lo && stat.lo_hit);

    always_comb
    begin
        stat            = '0;
        stat.zero_err   = (ext_reg == '0) || (lo_lim_reg == '0) || (hi_lim_reg == '0);
        stat.round_done = !(lo_reg < SZ_W'(lo_lim_reg)) && !(hi_dbl <= SZ_W'(hi_lim_reg));
        stat.lo_gt_hi   = lo_reg > hi_reg;
        stat.scan_last  = p_reg[SCAN_BITS-1];
        stat.over       = cnt_reg > CNT_MAX;
        stat.div_done   = d_reg[0];
        stat.hi_zero    = (w_reg == '0);
        stat.hi_last    = (w_reg == ONE_S) && (r_reg == '0);
        stat.lo_hit     = |(r_reg & p_reg);
        stat.lo_last    = ((r_reg & ~p_reg) == '0);
        stat.out_free   = !out_valid_reg || tile.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_w_reg      <= MIN_RESET;
            max_w_reg      <= MAX_RESET;
            min_h_reg      <= MIN_RESET;
            max_h_reg      <= MAX_RESET;
            single_cfg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_W:  min_w_reg      <= cfg_data;
                REG_MAX_W:  max_w_reg      <= cfg_data;
                REG_MIN_H:  min_h_reg      <= cfg_data;
                REG_MAX_H:  max_h_reg      <= cfg_data;
                REG_SINGLE: single_cfg_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ext_reg       <= extent & EXT_MASK;
            lo_lim_reg    <= axis ? min_h_reg : min_w_reg;
            hi_lim_reg    <= axis ? max_h_reg : max_w_reg;
            single_reg    <= single_cfg_reg;
            lo_reg        <= ONE_S;
            hi_reg        <= ONE_S;
            p_reg         <= ONE_S;
            weight_reg    <= ONE_S;
            cnt_reg       <= '0;
            small_any_reg <= 1'b0;
            small_two_reg <= 1'b0;
            small_top_reg <= '0;
            idx_reg       <= '0;
        end
        if (cmd.round_step)
        begin
            if (lo_reg < SZ_W'(lo_lim_reg))
                lo_reg <= lo_reg << 1;
            if (hi_dbl <= SZ_W'(hi_lim_reg))
                hi_reg <= hi_dbl;
        end
        if (cmd.scan_step)
        begin
            // bits above the maximum count as several maximum tiles
            if (bit_set)
                cnt_reg <= (cnt_sum > (SZ_W+1)'(MAX_BLOCKS)) ? CNT_SAT : cnt_sum[CNT_W-1:0];
            if (p_reg >= hi_reg)
                weight_reg <= weight_reg << 1;
            if (bit_set && (p_reg < lo_reg))
            begin
                small_two_reg <= small_any_reg;
                small_any_reg <= 1'b1;
                small_top_reg <= p_reg;
            end
            p_reg <= p_reg << 1;
        end
        if (cmd.merge)
        begin
            w_reg <= w_new;
            r_reg <= w_new & (hi_reg - ONE_S);
            d_reg <= hi_reg;
            p_reg <= hi_reg >> 1;
        end
        if (cmd.shift_step)
        begin
            w_reg <= w_reg >> 1;
            d_reg <= d_reg >> 1;
        end
        if (cmd.emit_hi)
        begin
            w_reg   <= w_reg - ONE_S;
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.emit_lo)
        begin
            p_reg <= p_reg >> 1;
            if (stat.lo_hit)
            begin
                r_reg   <= r_reg & ~p_reg;
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (tile.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (cmd.emit_err)
            begin
                out_size_reg <= '0;
                out_idx_reg  <= '0;
                out_last_reg <= 1'b1;
                out_err_reg  <= 1'b1;
            end
            else if (cmd.emit_hi)
            begin
                out_size_reg <= hi_reg;
                out_idx_reg  <= idx_reg;
                out_last_reg <= stat.hi_last;
                out_err_reg  <= 1'b0;
            end
            else
            begin
                out_size_reg <= p_reg;
                out_idx_reg  <= idx_reg;
                out_last_reg <= stat.lo_last;
                out_err_reg  <= 1'b0;
            end
        end
    end

    assign tile.valid      = out_valid_reg;
    assign tile.tile_size  = out_size_reg;
    assign tile.tile_index = out_idx_reg;
    assign tile.last       = out_last_reg;
    assign tile.error      = out_err_reg;

endmodule
